### hdl/wsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types, codes and helper functions shared by the deframer modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_HDR1   = 3'd0,
      PH_HDR2   = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_MASK   = 3'd3,
      PH_DATA   = 3'd4
   } wsfd_phase_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_DELIVER = 2'd1,
      ACT_PONG    = 2'd2,
      ACT_CLOSE   = 2'd3
   } wsfd_action_type;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] MASK_BYTES  = 4'd4;

   typedef struct packed {
      logic            has_data;
      logic [7:0]      data_byte;
      logic [3:0]      frame_opcode;
      logic            frame_fin;
      logic            frame_end;
      wsfd_action_type action;
      logic            link_closed;
   } wsfd_result_type;

   function automatic wsfd_action_type frame_action(input logic [3:0] opcode,
                                                    input logic       fin);
      wsfd_action_type act;
      act = ACT_NONE;
      priority if ((opcode == OP_TEXT || opcode == OP_CONT) && fin) begin
         act = ACT_DELIVER;
      end else if (opcode == OP_PING) begin
         act = ACT_PONG;
      end else if (opcode == OP_CLOSE) begin
         act = ACT_CLOSE;
      end else begin
         act = ACT_NONE;
      end
      return act;
   endfunction

endpackage

### hdl/wsfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer parse stage
// Holds the frame state and turns one stream word into at most one result.
// ----------------------------------------------------------------------------
module wsfd_parser #(
   parameter int LEN_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [7:0]                rx_byte,
   output logic                      res_valid,
   output wsfd_pkg::wsfd_result_type res
);

   wsfd_pkg::wsfd_phase_type phase_ff, phase_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic [3:0]               opcode_ff, opcode_in;
   logic                     fin_ff, fin_in;
   logic                     masked_ff, masked_in;
   logic [LEN_WIDTH-1:0]     len_ff, len_in;
   logic [31:0]              key_ff, key_in;
   logic [1:0]               idx_ff, idx_in;
   logic                     closed_ff, closed_in;

   logic [6:0]               code;
   logic [LEN_WIDTH-1:0]     code_len;
   logic [3:0]               cnt_dec;
   logic [LEN_WIDTH-1:0]     len_shift;
   logic [7:0]               key_byte;
   logic                     last_data;
   logic                     marker;
   logic                     frame_done;
   wsfd_pkg::wsfd_action_type act;

   assign code      = rx_byte[6:0];
   assign code_len  = {{(LEN_WIDTH-7){1'b0}}, code};
   assign cnt_dec   = (cnt_ff != 4'd0) ? cnt_ff - 4'd1 : 4'd0;
   assign len_shift = {len_ff[LEN_WIDTH-9:0], rx_byte};
   // In the payload, len_ff counts the bytes still to come.
   assign last_data = (len_ff[LEN_WIDTH-1:1] == '0);
   assign act       = wsfd_pkg::frame_action(opcode_ff, fin_ff);

   // Mask key bytes are used most significant first.
   always_comb begin
      unique case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Empty frame: the word that completes the header also ends the frame.
   always_comb begin
      marker = 1'b0;
      unique case (phase_ff)
         wsfd_pkg::PH_HDR2:
            marker = (code != wsfd_pkg::LEN_CODE_16) && (code != wsfd_pkg::LEN_CODE_64)
                     && !rx_byte[7] && (code == 7'd0);
         wsfd_pkg::PH_EXTLEN:
            marker = (cnt_dec == 4'd0) && !masked_ff && (len_shift == '0);
         wsfd_pkg::PH_MASK:
            marker = (cnt_dec == 4'd0) && (len_ff == '0);
         default:
            marker = 1'b0;
      endcase
   end

   // Output logic.
   always_comb begin
      frame_done       = 1'b0;
      res_valid        = 1'b0;
      res.has_data     = 1'b0;
      res.data_byte    = 8'd0;
      res.frame_opcode = opcode_ff;
      res.frame_fin    = fin_ff;
      res.frame_end    = 1'b0;
      res.action       = wsfd_pkg::ACT_NONE;
      res.link_closed  = closed_ff;
      if (go) begin
         if (phase_ff == wsfd_pkg::PH_DATA) begin
            res_valid     = 1'b1;
            res.has_data  = 1'b1;
            res.data_byte = rx_byte ^ key_byte;
            frame_done    = last_data;
         end else if (marker) begin
            res_valid  = 1'b1;
            frame_done = 1'b1;
         end
      end
      if (frame_done) begin
         res.frame_end   = 1'b1;
         res.action      = act;
         res.link_closed = closed_ff | (act == wsfd_pkg::ACT_CLOSE);
      end
   end

   // Next-state logic.
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      closed_in = res.link_closed;
      if (go) begin
         unique case (phase_ff)
            wsfd_pkg::PH_HDR2: begin
               masked_in = rx_byte[7];
               len_in    = '0;
               priority if (code == wsfd_pkg::LEN_CODE_16) begin
                  phase_in = wsfd_pkg::PH_EXTLEN;
                  cnt_in   = wsfd_pkg::EXT16_BYTES;
               end else if (code == wsfd_pkg::LEN_CODE_64) begin
                  phase_in = wsfd_pkg::PH_EXTLEN;
                  cnt_in   = wsfd_pkg::EXT64_BYTES;
               end else if (rx_byte[7]) begin
                  len_in   = code_len;
                  phase_in = wsfd_pkg::PH_MASK;
                  cnt_in   = wsfd_pkg::MASK_BYTES;
               end else begin
                  len_in   = code_len;
                  key_in   = '0;
                  idx_in   = 2'd0;
                  phase_in = marker ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DATA;
               end
            end
            wsfd_pkg::PH_EXTLEN: begin
               len_in = len_shift;
               cnt_in = cnt_dec;
               if (cnt_dec == 4'd0) begin
                  if (masked_ff) begin
                     phase_in = wsfd_pkg::PH_MASK;
                     cnt_in   = wsfd_pkg::MASK_BYTES;
                  end else begin
                     key_in   = '0;
                     idx_in   = 2'd0;
                     phase_in = marker ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DATA;
                  end
               end
            end
            wsfd_pkg::PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte};
               cnt_in = cnt_dec;
               if (cnt_dec == 4'd0) begin
                  idx_in   = 2'd0;
                  phase_in = marker ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DATA;
               end
            end
            wsfd_pkg::PH_DATA: begin
               idx_in = idx_ff + 2'd1;
               len_in = len_ff - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
               if (last_data) begin
                  phase_in = wsfd_pkg::PH_HDR1;
               end
            end
            default: begin
               fin_in    = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = wsfd_pkg::PH_HDR2;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsfd_pkg::PH_HDR1;
         cnt_ff    <= 4'd0;
         opcode_ff <= 4'd0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         len_ff    <= '0;
         key_ff    <= '0;
         idx_ff    <= 2'd0;
         closed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         len_ff    <= len_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         closed_ff <= closed_in;
      end
   end

   a_marker_ends_frame : assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.has_data |-> res.frame_end)
      else $error("empty-frame marker without frame end");

   a_closed_sticky : assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed flag cleared after being set");

   a_end_returns_to_header : assert property (@(posedge clock) disable iff (reset)
      res_valid && res.frame_end |=> phase_ff == wsfd_pkg::PH_HDR1)
      else $error("frame ended but parser did not return to header");

endmodule

### hdl/wsfd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer result buffer
// Output register with a skid entry so the parse stage sees a registered full.
// ----------------------------------------------------------------------------
module wsfd_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wsfd_pkg::wsfd_result_type push_res,
   output logic                      full,
   output logic                      out_valid,
   input  logic                      out_stall,
   output wsfd_pkg::wsfd_result_type out_res
);

   logic                      main_valid_ff, main_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   wsfd_pkg::wsfd_result_type main_ff, main_in;
   wsfd_pkg::wsfd_result_type skid_ff, skid_in;
   logic                      main_free;

   assign main_free = !main_valid_ff || !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         main_valid_in = skid_valid_ff | push;
         main_in       = skid_valid_ff ? skid_ff : push_res;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed while skid entry occupied");

   a_skid_behind_main : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a word while output register is empty");

   a_skid_drains_first : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_stall |=> main_valid_ff && main_ff == $past(skid_ff))
      else $error("skid word not moved to output register");

endmodule

### hdl/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received WebSocket byte stream into unmasked payload words.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and keeps that rate with no gaps
// as long as the result side is not stalled. A byte goes through an input
// register, then through the parse logic into a result register. Header, length
// and mask-key bytes give no result; each payload byte gives one, and a frame
// with an empty payload gives one marker result with rsp_has_data low. The
// result register has a skid entry behind it, so the input keeps flowing after
// the result side stalls until the skid entry fills, and req_stall is formed
// from registers only. LEN_WIDTH sets the width of the held payload length
// (16 to 64 bits); longer lengths are kept modulo 2**LEN_WIDTH.
module websocket_frame_deframer_top #(
   parameter int LEN_WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_data,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_frame_fin,
   output logic       rsp_frame_end,
   output logic [1:0] rsp_action,
   output logic       rsp_link_closed
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff, in_byte_in;
   logic                      go;
   logic                      buf_full;
   logic                      res_valid;
   wsfd_pkg::wsfd_result_type res;
   wsfd_pkg::wsfd_result_type out_res;
   logic                      req_take;

   assign go        = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   wsfd_parser #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_res  (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   assign rsp_has_data     = out_res.has_data;
   assign rsp_data_byte    = out_res.data_byte;
   assign rsp_frame_opcode = out_res.frame_opcode;
   assign rsp_frame_fin    = out_res.frame_fin;
   assign rsp_frame_end    = out_res.frame_end;
   assign rsp_action       = out_res.action;
   assign rsp_link_closed  = out_res.link_closed;

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && buf_full)
      else $error("input stalled without a pending word");

   a_word_held_under_stall : assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && in_byte_ff == $past(in_byte_ff))
      else $error("pending input word lost during stall");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds the deframer a byte stream: a short directed table of frames, then
// random frames with mixed length encodings, masks and opcodes. Each accepted
// word is run through a local frame predictor, and every result word is
// checked field by field against the oldest prediction, under several
// sender and receiver idle mixes and one long receiver hold.
// ----------------------------------------------------------------------------
module tb;

   localparam int LEN_W          = 64;
   localparam int DIR_ROWS       = 25;
   localparam int PHASE_WORDS    = 400;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 1000;

   // Length encodings of the second header byte.
   localparam int ENC_SHORT = 0;
   localparam int ENC_16    = 1;
   localparam int ENC_64    = 2;

   typedef struct packed {
      logic [7:0]                rx;
      logic                      typed;
      wsfd_pkg::wsfd_result_type want;
   } stim_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_has_data;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_frame_fin;
   logic       rsp_frame_end;
   logic [1:0] rsp_action;
   logic       rsp_link_closed;

   websocket_frame_deframer_top #(
      .LEN_WIDTH(LEN_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_has_data    (rsp_has_data),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_frame_opcode(rsp_frame_opcode),
      .rsp_frame_fin   (rsp_frame_fin),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_action      (rsp_action),
      .rsp_link_closed (rsp_link_closed)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   stim_word_type             tx_words[$];
   wsfd_pkg::wsfd_result_type pending_results[$];
   stim_word_type             cur_word = '0;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_rsp = 1'b0;
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned results_seen = 0;
   int unsigned frames_ended = 0;
   int unsigned delivers_seen = 0;
   int unsigned pongs_seen = 0;
   int unsigned closes_seen = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;

   // Frame parser state of the predictor.
   wsfd_pkg::wsfd_phase_type st_phase = wsfd_pkg::PH_HDR1;
   logic [3:0]               st_left = '0;
   logic [3:0]               st_op = '0;
   logic                     st_fin = 1'b0;
   logic                     st_masked = 1'b0;
   logic [LEN_W-1:0]         st_len = '0;
   logic [31:0]              st_key = '0;
   logic [63:0]              st_idx = '0;
   logic                     st_closed = 1'b0;

   task automatic take_action(output wsfd_pkg::wsfd_action_type act);
      if ((st_op == wsfd_pkg::OP_TEXT || st_op == wsfd_pkg::OP_CONT) && st_fin) begin
         act = wsfd_pkg::ACT_DELIVER;
      end else if (st_op == wsfd_pkg::OP_PING) begin
         act = wsfd_pkg::ACT_PONG;
      end else if (st_op == wsfd_pkg::OP_CLOSE) begin
         act = wsfd_pkg::ACT_CLOSE;
         st_closed = 1'b1;
      end else begin
         act = wsfd_pkg::ACT_NONE;
      end
   endtask

   task automatic fill_frame_fields(inout wsfd_pkg::wsfd_result_type r);
      r.frame_opcode = st_op;
      r.frame_fin    = st_fin;
      r.link_closed  = st_closed;
   endtask

   task automatic finish_header(output bit got, output wsfd_pkg::wsfd_result_type r);
      got = 1'b0;
      r   = '0;
      st_idx = '0;
      if (st_len == '0) begin
         // Empty payload: one marker word closes the frame.
         got = 1'b1;
         r.frame_end = 1'b1;
         take_action(r.action);
         fill_frame_fields(r);
         st_phase = wsfd_pkg::PH_HDR1;
      end else begin
         st_phase = wsfd_pkg::PH_DATA;
      end
   endtask

   task automatic finish_length(output bit got, output wsfd_pkg::wsfd_result_type r);
      got = 1'b0;
      r   = '0;
      if (st_masked) begin
         st_phase = wsfd_pkg::PH_MASK;
         st_left  = wsfd_pkg::MASK_BYTES;
      end else begin
         st_key = '0;
         finish_header(got, r);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b, output bit got,
                               output wsfd_pkg::wsfd_result_type r);
      logic [7:0] key_byte;
      got = 1'b0;
      r   = '0;
      case (st_phase)
         wsfd_pkg::PH_HDR2: begin
            st_masked = b[7];
            st_len    = '0;
            if (b[6:0] == wsfd_pkg::LEN_CODE_16) begin
               st_phase = wsfd_pkg::PH_EXTLEN;
               st_left  = wsfd_pkg::EXT16_BYTES;
            end else if (b[6:0] == wsfd_pkg::LEN_CODE_64) begin
               st_phase = wsfd_pkg::PH_EXTLEN;
               st_left  = wsfd_pkg::EXT64_BYTES;
            end else begin
               st_len[6:0] = b[6:0];
               finish_length(got, r);
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            st_len = {st_len[LEN_W-9:0], b};
            if (st_left != 4'd0) st_left = st_left - 4'd1;
            if (st_left == 4'd0) finish_length(got, r);
         end
         wsfd_pkg::PH_MASK: begin
            st_key = {st_key[23:0], b};
            if (st_left != 4'd0) st_left = st_left - 4'd1;
            if (st_left == 4'd0) finish_header(got, r);
         end
         wsfd_pkg::PH_DATA: begin
            key_byte = st_key[8 * (3 - st_idx[1:0]) +: 8];
            st_idx = st_idx + 64'd1;
            got = 1'b1;
            r.has_data  = 1'b1;
            r.data_byte = b ^ key_byte;
            if (st_idx >= st_len) begin
               r.frame_end = 1'b1;
               take_action(r.action);
               st_phase = wsfd_pkg::PH_HDR1;
            end
            fill_frame_fields(r);
         end
         default: begin
            st_fin   = b[7];
            st_op    = b[3:0];
            st_phase = wsfd_pkg::PH_HDR2;
         end
      endcase
   endtask

   function automatic wsfd_pkg::wsfd_result_type result_word(
         logic has, logic [7:0] data, logic [3:0] op, logic fin,
         wsfd_pkg::wsfd_action_type act, logic closed);
      wsfd_pkg::wsfd_result_type r;
      r.has_data     = has;
      r.data_byte    = data;
      r.frame_opcode = op;
      r.frame_fin    = fin;
      r.frame_end    = 1'b1;
      r.action       = act;
      r.link_closed  = closed;
      return r;
   endfunction

   function automatic stim_word_type row_p(logic [7:0] rx);
      stim_word_type w;
      w = '0;
      w.rx = rx;
      return w;
   endfunction

   function automatic stim_word_type row_t(logic [7:0] rx,
                                           wsfd_pkg::wsfd_result_type want);
      stim_word_type w;
      w.rx    = rx;
      w.typed = 1'b1;
      w.want  = want;
      return w;
   endfunction

   task automatic push_word(input logic [7:0] b);
      tx_words.push_back(row_p(b));
      words_queued++;
   endtask

   task automatic queue_frame(input logic [7:0] hdr1, input logic masked,
                              input int enc, input logic [63:0] len,
                              input int unsigned payload_words);
      push_word(hdr1);
      case (enc)
         ENC_16: begin
            push_word({masked, wsfd_pkg::LEN_CODE_16});
            push_word(len[15:8]);
            push_word(len[7:0]);
         end
         ENC_64: begin
            push_word({masked, wsfd_pkg::LEN_CODE_64});
            for (int i = 7; i >= 0; i--) push_word(len[8*i +: 8]);
         end
         default: begin
            push_word({masked, len[6:0]});
         end
      endcase
      if (masked) repeat (4) push_word(8'($urandom));
      repeat (payload_words) push_word(8'($urandom));
   endtask

   // Half of the frames are well-formed frames of the common opcodes; the rest
   // carry any opcode nibble. Header reserved bits and fin are always random.
   task automatic random_frame();
      logic [7:0]  hdr1;
      int unsigned pick;
      int unsigned len;
      int          enc;
      hdr1 = 8'($urandom);
      pick = $urandom_range(9);
      case (pick)
         0:       hdr1[3:0] = wsfd_pkg::OP_CONT;
         1, 2:    hdr1[3:0] = wsfd_pkg::OP_TEXT;
         3:       hdr1[3:0] = wsfd_pkg::OP_CLOSE;
         4:       hdr1[3:0] = wsfd_pkg::OP_PING;
         default: hdr1[3:0] = hdr1[3:0];
      endcase
      pick = $urandom_range(99);
      if (pick < 25) len = 0;
      else if (pick < 93) len = $urandom_range(1, 24);
      else len = $urandom_range(126, 300);
      pick = $urandom_range(9);
      if (len >= 126) enc = (pick < 6) ? ENC_16 : ENC_64;
      else if (pick < 6) enc = ENC_SHORT;
      else if (pick < 8) enc = ENC_16;
      else enc = ENC_64;
      queue_frame(hdr1, 1'($urandom), enc, 64'(len), len);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, name, want, got);
      end
   endtask

   // Sender: offers the next word, and predicts each word as it is accepted.
   always @(posedge clock) begin
      stim_word_type             w;
      bit                        got;
      wsfd_pkg::wsfd_result_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            words_taken++;
            deframe_byte(cur_word.rx, got, r);
            if (cur_word.typed) begin
               pending_results.push_back(cur_word.want);
            end else if (got) begin
               pending_results.push_back(r);
            end
         end
         if (!req_valid || !req_stall) begin
            if (tx_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               w = tx_words.pop_front();
               cur_word    <= w;
               req_valid   <= 1'b1;
               req_rx_byte <= w.rx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
      end
   end

   // Long receiver hold while the sender keeps offering, so the block backs up.
   initial begin
      wait (words_taken >= 150);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      wsfd_pkg::wsfd_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_frame_end) begin
            frames_ended++;
            if (rsp_action == wsfd_pkg::ACT_DELIVER) delivers_seen++;
            if (rsp_action == wsfd_pkg::ACT_PONG) pongs_seen++;
            if (rsp_action == wsfd_pkg::ACT_CLOSE) closes_seen++;
         end
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t ns: result word with none expected, data %0h",
                     $time, rsp_data_byte);
         end else begin
            want = pending_results.pop_front();
            check_field("has_data", 8'(want.has_data), 8'(rsp_has_data));
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("frame_opcode", 8'(want.frame_opcode), 8'(rsp_frame_opcode));
            check_field("frame_fin", 8'(want.frame_fin), 8'(rsp_frame_fin));
            check_field("frame_end", 8'(want.frame_end), 8'(rsp_frame_end));
            check_field("action", 8'(want.action), 8'(rsp_action));
            check_field("link_closed", 8'(want.link_closed), 8'(rsp_link_closed));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no word moved for %0d cycles",
                     $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   stim_word_type dir_table [DIR_ROWS];

   initial begin
      dir_table = '{
         row_p(8'h81),
         row_t(8'h00, result_word(1'b0, 8'h00, wsfd_pkg::OP_TEXT, 1'b1,
                                  wsfd_pkg::ACT_DELIVER, 1'b0)),
         row_p(8'h89),
         row_t(8'h00, result_word(1'b0, 8'h00, wsfd_pkg::OP_PING, 1'b1,
                                  wsfd_pkg::ACT_PONG, 1'b0)),
         row_p(8'h02),
         row_p(8'h01),
         row_t(8'hFF, result_word(1'b1, 8'hFF, 4'h2, 1'b0, wsfd_pkg::ACT_NONE, 1'b0)),
         // Continuation with fin, masked, 16-bit length of two.
         row_p(8'h80),
         row_p(8'hFE),
         row_p(8'h00),
         row_p(8'h02),
         row_p(8'hAA),
         row_p(8'h55),
         row_p(8'h0F),
         row_p(8'hF0),
         row_p(8'h00),
         row_p(8'hFF),
         row_p(8'h88),
         row_t(8'h00, result_word(1'b0, 8'h00, wsfd_pkg::OP_CLOSE, 1'b1,
                                  wsfd_pkg::ACT_CLOSE, 1'b1)),
         // Reserved bits set, unknown opcode, masked empty payload.
         row_p(8'h7F),
         row_p(8'h80),
         row_p(8'h12),
         row_p(8'h34),
         row_p(8'h56),
         row_t(8'h78, result_word(1'b0, 8'h00, 4'hF, 1'b0, wsfd_pkg::ACT_NONE, 1'b1))
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         tx_words.push_back(dir_table[i]);
         words_queued++;
      end

      for (int ph = 0; ph < 4; ph++) begin
         int unsigned target;
         case (ph)
            1:       begin idle_pct = 78; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 78; end
            3:       begin idle_pct = 6;  stall_pct = 6;  end
            default: begin idle_pct = 0;  stall_pct = 0;  end
         endcase
         target = words_queued + PHASE_WORDS;
         while (words_queued < target) begin
            while (tx_words.size() > 32) @(posedge clock);
            random_frame();
         end
      end

      // A 64-bit length with its top bit set: the frame never ends here,
      // but every payload word still comes out unmasked.
      queue_frame({1'b1, 3'b000, wsfd_pkg::OP_TEXT}, 1'b1, ENC_64,
                  64'h8000_0000_0000_0030, 40);

      while (tx_words.size() != 0 || req_valid) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d stream words and %0d result words, %0d frame ends",
               words_taken, results_seen, frames_ended);
      $display("with %0d deliveries, %0d pongs and %0d closes under four idle mixes.",
               delivers_seen, pongs_seen, closes_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hdl/wsfd_pkg.sv
hdl/wsfd_parser.sv
hdl/wsfd_out_buf.sv
hdl/websocket_frame_deframer_top.sv
tb/tb.sv
